/* src/ppkf_pkg.sv */
package ppkf_pkg;

    typedef struct packed {
        logic [1:0]          mode;
        logic [47:0]         stamp;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [15:0]  heading;
        logic signed [31:0]  lin_vel;
        logic signed [31:0]  ang_vel;
        logic                dropout_on;
    } req_t;

    typedef struct packed {
        logic signed [31:0]  est_x;
        logic signed [31:0]  est_y;
        logic signed [15:0]  est_heading;
        logic [31:0]         var_x_out;
        logic [31:0]         var_y_out;
        logic [31:0]         var_heading_out;
    } rsp_t;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CMD    = 2'd1;
    localparam logic [1:0] MODE_DROP   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic CFG_PROCESS_NOISE = 1'b0;
    localparam logic CFG_MEAS_NOISE    = 1'b1;

    localparam logic [31:0] PN_RESET = 32'd167772;
    localparam logic [31:0] MN_RESET = 32'd838861;
    localparam logic [31:0] VAR_ONE  = 32'd16777216;
    localparam logic [47:0] ONE_SECOND = 48'd65536;

    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_CNT_W  = 6;
    localparam int DIV_STEPS  = 31;
    localparam int DIV_CNT_W  = 5;
    localparam int WRAP_STEPS = 16;
    localparam int WRAP_CNT_W = 4;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_CNT_W = 5;

    localparam logic signed [31:0] PI_Q13      = 32'sd25736;
    localparam logic signed [31:0] WRAP_OFFSET = 32'sd843317248;
    localparam logic [31:0]        WRAP_MOD_TOP = 32'd1686634496;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;
    localparam logic signed [33:0] GAIN_ONE    = 34'sd1073741824;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:  a = 34'sd843314857;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043837;
            5'd3:  a = 34'sd133525159;
            5'd4:  a = 34'sd67021687;
            5'd5:  a = 34'sd33543516;
            5'd6:  a = 34'sd16775851;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194283;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048576;
            5'd11: a = 34'sd524288;
            5'd12: a = 34'sd262144;
            5'd13: a = 34'sd131072;
            5'd14: a = 34'sd65536;
            5'd15: a = 34'sd32768;
            5'd16: a = 34'sd16384;
            5'd17: a = 34'sd8192;
            5'd18: a = 34'sd4096;
            5'd19: a = 34'sd2048;
            5'd20: a = 34'sd1024;
            5'd21: a = 34'sd512;
            5'd22: a = 34'sd256;
            5'd23: a = 34'sd128;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

/* src/planar_pose_kalman_filter_top.sv */
// A velocity command, a dropout setting or a dropped sample is taken in idle and gives no result.
// The first sample sets the pose after one heading wrap; a full sample runs to the result through
// ten bit-serial multiplies, three divisions, a 24-step CORDIC and 16-step heading wraps, all run
// one after another; in dropout the three divisions and six correction multiplies are skipped.
// Throughput: one item at a time; after a full sample the next is taken once its result is in the output register.
// Reset: asynchronous, active low; pose, stamp and flags clear, variances load 1.0.
module planar_pose_kalman_filter_top
    import ppkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_WRAP, S_CORD, S_MUL_VD, S_MUL_X, S_MUL_Y, S_MUL_H, S_WRAP_H,
        S_VAR, S_INNOV_H, S_DIV, S_MUL_E, S_MUL_V, S_WRAP_E, S_OUT
    } state_t;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_H = 2'd2;

    state_t                   state_reg;
    req_t                     item_reg;
    rsp_t                     rsp_data_reg;
    logic                     rsp_valid_reg;
    logic [31:0]              process_noise_reg;
    logic [31:0]              meas_noise_reg;
    logic signed [31:0]       pose_x_reg;
    logic signed [31:0]       pose_y_reg;
    logic signed [15:0]       pose_h_reg;
    logic [31:0]              var_reg [3];
    logic [47:0]              prev_stamp_reg;
    logic                     started_reg;
    logic signed [31:0]       cmd_lin_reg;
    logic signed [31:0]       cmd_ang_reg;
    logic                     cmd_seen_reg;
    logic                     dropout_reg;
    logic [16:0]              dt_reg;
    logic signed [32:0]       cos_reg;
    logic signed [32:0]       sin_reg;
    logic signed [33:0]       vd_reg;
    logic signed [32:0]       innov_reg;
    logic [30:0]              gain_reg;
    logic [1:0]               axis_reg;
    logic signed [MUL_W-1:0]  mul_a_reg;
    logic signed [MUL_W-1:0]  mul_b_reg;
    logic                     mul_start_reg;
    logic                     div_start_reg;
    logic                     cord_start_reg;
    logic                     wrap_start_reg;
    logic signed [29:0]       wrap_in_reg;

    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_p;
    logic                     div_done;
    logic [30:0]              div_q;
    logic [31:0]              div_pv;
    logic [32:0]              div_den;
    logic                     cord_done;
    logic signed [32:0]       cos_val;
    logic signed [32:0]       sin_val;
    logic                     wrap_done;
    logic signed [15:0]       wrap_res;

    logic signed [31:0]       v_sel;
    logic signed [31:0]       w_sel;
    logic [47:0]              stamp_diff;
    logic signed [PROD_W-1:0] rnd16;
    logic signed [PROD_W-1:0] rnd19;
    logic signed [PROD_W-1:0] rnd30;
    logic signed [33:0]       vd_calc;
    logic signed [37:0]       step_calc;
    logic signed [29:0]       dh_calc;
    logic signed [34:0]       e_calc;
    logic signed [34:0]       corr_x;
    logic signed [34:0]       corr_y;
    logic signed [38:0]       pred_x;
    logic signed [38:0]       pred_y;
    logic [31:0]              var_calc;
    logic signed [29:0]       innov_h_in;
    logic [32:0]              var_add [3];

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -39'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign v_sel      = cmd_seen_reg ? cmd_lin_reg : item_reg.lin_vel;
    assign w_sel      = cmd_seen_reg ? cmd_ang_reg : item_reg.ang_vel;
    assign stamp_diff = req_data.stamp - prev_stamp_reg;

    assign rnd16     = mul_p + 68'sd32768;
    assign rnd19     = mul_p + 68'sd262144;
    assign rnd30     = mul_p + 68'sd536870912;
    assign vd_calc   = $signed(rnd16[49:16]);
    assign step_calc = $signed(rnd30[67:30]);
    assign dh_calc   = $signed(rnd19[48:19]);
    assign e_calc    = $signed(rnd30[64:30]);
    assign var_calc  = rnd30[61:30];
    assign pred_x    = 39'(pose_x_reg) + 39'(step_calc);
    assign pred_y    = 39'(pose_y_reg) + 39'(step_calc);
    assign corr_x    = 35'(pose_x_reg) + e_calc;
    assign corr_y    = 35'(pose_y_reg) + e_calc;
    assign innov_h_in = 30'(item_reg.heading) - 30'(pose_h_reg);

    assign div_pv  = var_reg[axis_reg];
    assign div_den = {1'b0, div_pv} + {1'b0, meas_noise_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            var_add[i] = {1'b0, var_reg[i]} + {1'b0, process_noise_reg};
        end
    end

    ppkf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    ppkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .pv    (div_pv),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q)
    );

    ppkf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start_reg),
        .angle   (pose_h_reg),
        .done    (cord_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    ppkf_wrap u_wrap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wrap_start_reg),
        .value (wrap_in_reg),
        .done  (wrap_done),
        .res   (wrap_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            item_reg          <= '0;
            rsp_data_reg      <= '0;
            rsp_valid_reg     <= 1'b0;
            process_noise_reg <= PN_RESET;
            meas_noise_reg    <= MN_RESET;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            pose_h_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                var_reg[i] <= VAR_ONE;
            end
            prev_stamp_reg    <= '0;
            started_reg       <= 1'b0;
            cmd_lin_reg       <= '0;
            cmd_ang_reg       <= '0;
            cmd_seen_reg      <= 1'b0;
            dropout_reg       <= 1'b0;
            dt_reg            <= '0;
            cos_reg           <= '0;
            sin_reg           <= '0;
            vd_reg            <= '0;
            innov_reg         <= '0;
            gain_reg          <= '0;
            axis_reg          <= AX_X;
            mul_a_reg         <= '0;
            mul_b_reg         <= '0;
            mul_start_reg     <= 1'b0;
            div_start_reg     <= 1'b0;
            cord_start_reg    <= 1'b0;
            wrap_start_reg    <= 1'b0;
            wrap_in_reg       <= '0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            cord_start_reg <= 1'b0;
            wrap_start_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    CFG_MEAS_NOISE:    meas_noise_reg    <= cfg_data;
                endcase
            end

            if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg <= req_data;
                        unique case (req_data.mode)
                            MODE_CMD:
                            begin
                                cmd_lin_reg  <= req_data.lin_vel;
                                cmd_ang_reg  <= req_data.ang_vel;
                                cmd_seen_reg <= 1'b1;
                            end
                            MODE_DROP:
                            begin
                                dropout_reg <= req_data.dropout_on;
                            end
                            MODE_SAMPLE:
                            begin
                                prev_stamp_reg <= req_data.stamp;
                                if (!started_reg)
                                begin
                                    wrap_in_reg    <= 30'(req_data.heading);
                                    wrap_start_reg <= 1'b1;
                                    state_reg      <= S_INIT_WRAP;
                                end
                                else if (req_data.stamp > prev_stamp_reg &&
                                         stamp_diff <= ONE_SECOND)
                                begin
                                    dt_reg         <= stamp_diff[16:0];
                                    cord_start_reg <= 1'b1;
                                    state_reg      <= S_CORD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_INIT_WRAP:
                begin
                    if (wrap_done)
                    begin
                        pose_x_reg  <= item_reg.pos_x;
                        pose_y_reg  <= item_reg.pos_y;
                        pose_h_reg  <= wrap_res;
                        started_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_CORD:
                begin
                    if (cord_done)
                    begin
                        cos_reg       <= cos_val;
                        sin_reg       <= sin_val;
                        mul_a_reg     <= 34'(v_sel);
                        mul_b_reg     <= {17'b0, dt_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_VD;
                    end
                end
                S_MUL_VD:
                begin
                    if (mul_done)
                    begin
                        vd_reg        <= vd_calc;
                        mul_a_reg     <= vd_calc;
                        mul_b_reg     <= 34'(cos_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_X;
                    end
                end
                S_MUL_X:
                begin
                    if (mul_done)
                    begin
                        pose_x_reg    <= sat32(pred_x);
                        mul_a_reg     <= vd_reg;
                        mul_b_reg     <= 34'(sin_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_Y;
                    end
                end
                S_MUL_Y:
                begin
                    if (mul_done)
                    begin
                        pose_y_reg    <= sat32(pred_y);
                        mul_a_reg     <= 34'(w_sel);
                        mul_b_reg     <= {17'b0, dt_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_H;
                    end
                end
                S_MUL_H:
                begin
                    if (mul_done)
                    begin
                        wrap_in_reg    <= 30'(pose_h_reg) + dh_calc;
                        wrap_start_reg <= 1'b1;
                        state_reg      <= S_WRAP_H;
                    end
                end
                S_WRAP_H:
                begin
                    if (wrap_done)
                    begin
                        pose_h_reg <= wrap_res;
                        state_reg  <= S_VAR;
                    end
                end
                S_VAR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        var_reg[i] <= var_add[i][32] ? 32'hffffffff : var_add[i][31:0];
                    end
                    if (dropout_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        axis_reg      <= AX_X;
                        innov_reg     <= 33'(item_reg.pos_x) - 33'(pose_x_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_INNOV_H:
                begin
                    if (wrap_done)
                    begin
                        innov_reg     <= 33'(wrap_res);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        gain_reg      <= div_q;
                        mul_a_reg     <= 34'(innov_reg);
                        mul_b_reg     <= {3'b0, div_q};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_E;
                    end
                end
                S_MUL_E:
                begin
                    if (mul_done)
                    begin
                        unique case (axis_reg)
                            AX_X:    pose_x_reg  <= corr_x[31:0];
                            AX_Y:    pose_y_reg  <= corr_y[31:0];
                            default: wrap_in_reg <= 30'(pose_h_reg) + 30'(e_calc);
                        endcase
                        mul_a_reg     <= {2'b0, var_reg[axis_reg]};
                        mul_b_reg     <= GAIN_ONE - {3'b0, gain_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_V;
                    end
                end
                S_MUL_V:
                begin
                    if (mul_done)
                    begin
                        var_reg[axis_reg] <= var_calc;
                        unique case (axis_reg)
                            AX_X:
                            begin
                                axis_reg      <= AX_Y;
                                innov_reg     <= 33'(item_reg.pos_y) - 33'(pose_y_reg);
                                div_start_reg <= 1'b1;
                                state_reg     <= S_DIV;
                            end
                            AX_Y:
                            begin
                                axis_reg       <= AX_H;
                                wrap_in_reg    <= innov_h_in;
                                wrap_start_reg <= 1'b1;
                                state_reg      <= S_INNOV_H;
                            end
                            default:
                            begin
                                wrap_start_reg <= 1'b1;
                                state_reg      <= S_WRAP_E;
                            end
                        endcase
                    end
                end
                S_WRAP_E:
                begin
                    if (wrap_done)
                    begin
                        pose_h_reg <= wrap_res;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_data_reg.est_x           <= pose_x_reg;
                        rsp_data_reg.est_y           <= pose_y_reg;
                        rsp_data_reg.est_heading     <= pose_h_reg;
                        rsp_data_reg.var_x_out       <= var_reg[AX_X];
                        rsp_data_reg.var_y_out       <= var_reg[AX_Y];
                        rsp_data_reg.var_heading_out <= var_reg[AX_H];
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

/* src/ppkf_mul.sv */
module ppkf_mul
    import ppkf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic                     done,
    output logic signed [PROD_W-1:0] p
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] ash_reg;
    logic [MUL_W-1:0]         bsh_reg;
    logic signed [PROD_W-1:0] addend;
    logic                     last;

    assign last   = (cnt_reg == MUL_CNT_W'(MUL_W - 1));
    assign addend = bsh_reg[0] ? ash_reg : '0;
    assign acc_next = last ? acc_reg - addend : acc_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            ash_reg  <= '0;
            bsh_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                ash_reg  <= PROD_W'(a);
                bsh_reg  <= b;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                ash_reg <= ash_reg <<< 1;
                bsh_reg <= bsh_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* src/ppkf_div.sv */
module ppkf_div
    import ppkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] pv,
    input  logic [32:0] den,
    output logic        done,
    output logic [30:0] q
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [32:0]          rem_reg;
    logic [30:0]          nsh_reg;
    logic [30:0]          q_reg;
    logic [32:0]          den_reg;
    logic [62:0]          num;
    logic [33:0]          t;
    logic                 ge;

    assign num = {1'b0, pv, 30'b0} + {30'b0, den[32:1]};
    assign t   = {rem_reg, nsh_reg[30]};
    assign ge  = (t >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            nsh_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                zero_reg <= (den == 33'd0);
                cnt_reg  <= '0;
                den_reg  <= den;
                rem_reg  <= {1'b0, num[62:31]};
                nsh_reg  <= num[30:0];
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? 33'(t - {1'b0, den_reg}) : t[32:0];
                nsh_reg <= {nsh_reg[29:0], 1'b0};
                q_reg   <= {q_reg[29:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = zero_reg ? 31'd0 : q_reg;

endmodule

/* src/ppkf_cordic.sv */
module ppkf_cordic
    import ppkf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [32:0] cos_val,
    output logic signed [32:0] sin_val
);

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [CORDIC_CNT_W-1:0] cnt_reg;
    logic signed [32:0]      x_reg;
    logic signed [32:0]      y_reg;
    logic signed [33:0]      z_reg;
    logic signed [33:0]      z0;
    logic signed [32:0]      dx;
    logic signed [32:0]      dy;
    logic signed [33:0]      at;

    assign z0 = 34'(angle) <<< 17;
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = atan_q30(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                if (z0 > HALF_PI_Q30)
                begin
                    z_reg   <= z0 - PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (z0 < -HALF_PI_Q30)
                begin
                    z_reg   <= z0 + PI_Q30;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg   <= z0;
                    neg_reg <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_val = neg_reg ? -x_reg : x_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;

endmodule

/* src/ppkf_wrap.sv */
module ppkf_wrap
    import ppkf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [29:0] value,
    output logic               done,
    output logic signed [15:0] res
);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  gt_reg;
    logic                  lt_reg;
    logic [15:0]           low_reg;
    logic [WRAP_CNT_W-1:0] cnt_reg;
    logic [31:0]           r_reg;
    logic [31:0]           msh_reg;
    logic signed [31:0]    v32;
    logic signed [31:0]    b;
    logic signed [31:0]    r0;
    logic                  gt;
    logic                  lt;

    assign v32 = 32'(value);
    assign gt  = (v32 > PI_Q13);
    assign lt  = (v32 < -PI_Q13);
    assign b   = gt ? v32 + PI_Q13 - 32'sd1 : v32 + PI_Q13;
    assign r0  = (b < 0) ? b + WRAP_OFFSET : b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            gt_reg   <= 1'b0;
            lt_reg   <= 1'b0;
            low_reg  <= '0;
            cnt_reg  <= '0;
            r_reg    <= '0;
            msh_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                gt_reg   <= gt;
                lt_reg   <= lt;
                low_reg  <= value[15:0];
                cnt_reg  <= '0;
                r_reg    <= r0;
                msh_reg  <= WRAP_MOD_TOP;
            end
            else if (busy_reg)
            begin
                if (r_reg >= msh_reg)
                begin
                    r_reg <= r_reg - msh_reg;
                end
                msh_reg <= msh_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == WRAP_CNT_W'(WRAP_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = gt_reg ? 16'($signed(r_reg) - (PI_Q13 - 32'sd1)) :
                  lt_reg ? 16'($signed(r_reg) - PI_Q13) : $signed(low_reg);

endmodule
